// ===== sv/rles_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rles_pkg
// Shared types and constants of the RGB LED effect sequencer.
// ----------------------------------------------------------------------------
package rles_pkg;

  localparam int unsigned ColorW = 24;
  localparam int unsigned TicksW = 16;
  localparam int unsigned CountW = 16;

  typedef enum logic [3:0] {
    MODE_TICK    = 4'd0,
    MODE_SET     = 4'd1,
    MODE_STORE   = 4'd2,
    MODE_CLEAR   = 4'd3,
    MODE_ON      = 4'd4,
    MODE_OFF     = 4'd5,
    MODE_FADE    = 4'd6,
    MODE_BLINK   = 4'd7,
    MODE_RAINBOW = 4'd8
  } mode_e;

  typedef enum logic [1:0] {
    KIND_IDLE    = 2'd0,
    KIND_FADE    = 2'd1,
    KIND_BLINK   = 2'd2,
    KIND_RAINBOW = 2'd3
  } kind_e;

  localparam logic [7:0]        LastStep    = 8'd255;
  localparam logic [7:0]        WheelSeg1   = 8'd85;
  localparam logic [7:0]        WheelSeg2   = 8'd170;
  localparam logic [ColorW-1:0] WhiteColor  = 24'hff_ffff;

  typedef struct packed {
    logic [CountW-1:0] blink_count;
    logic [TicksW-1:0] step_ticks;
    logic [ColorW-1:0] color_word;
    logic [3:0]        mode;
  } item_t;

  typedef struct packed {
    logic [ColorW-1:0] stored_color;
    logic              lit;
    logic              busy_res;
    logic [7:0]        drive_blue;
    logic [7:0]        drive_green;
    logic [7:0]        drive_red;
  } result_t;

endpackage

// ===== sv/rles_in_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rles_in_reg
// Input register: holds one accepted item until the core consumes it.
// ----------------------------------------------------------------------------
module rles_in_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  rles_pkg::item_t item_i,
  output logic           valid_o,
  output rles_pkg::item_t item_o,
  input  logic           take_i
);
  import rles_pkg::*;

  logic  valid_q;
  item_t item_q;

  // The held item leaves in the same cycle a new one may enter.
  assign ready_o = !valid_q || take_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== sv/rles_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rles_core
// Effect state registers and the single-pass update for one item.
// ----------------------------------------------------------------------------
module rles_core #(
  parameter int unsigned DELAY_BITS = 16,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  rles_pkg::item_t   item_i,
  output rles_pkg::result_t result_o
);
  import rles_pkg::*;

  localparam int unsigned DW = DELAY_BITS;
  localparam int unsigned CW = COUNT_BITS;
  localparam int unsigned TW = COUNT_BITS + 1;

  function automatic logic [7:0] fade_chan(input logic [7:0] s, input logic [7:0] t,
                                           input logic [7:0] i);
    logic signed [9:0]  diff;
    logic signed [18:0] prod;
    logic signed [18:0] biased;
    logic [7:0]         q;
    diff   = $signed({2'b00, t}) - $signed({2'b00, s});
    prod   = $signed({1'b0, i}) * diff;
    // Bias negative products so the shift truncates toward zero.
    biased = prod[18] ? (prod + 19'sd255) : prod;
    q      = biased[15:8];
    return s + q;
  endfunction

  function automatic logic [ColorW-1:0] wheel(input logic [7:0] idx);
    logic [7:0] pos;
    logic [7:0] off;
    logic [9:0] p3;
    logic [7:0] up;
    logic [7:0] dn;
    pos = LastStep - idx;
    if (pos < WheelSeg1) begin
      off = pos;
    end else if (pos < WheelSeg2) begin
      off = pos - WheelSeg1;
    end else begin
      off = pos - WheelSeg2;
    end
    p3 = {2'b00, off} + {1'b0, off, 1'b0};
    up = p3[7:0];
    dn = LastStep - p3[7:0];
    if (pos < WheelSeg1) begin
      return {dn, 8'd0, up};
    end else if (pos < WheelSeg2) begin
      return {8'd0, up, dn};
    end else begin
      return {up, dn, 8'd0};
    end
  endfunction

  logic [ColorW-1:0] stored_q, stored_d;
  logic [ColorW-1:0] packed_q, packed_d;
  logic [ColorW-1:0] start_q, start_d;
  logic [ColorW-1:0] drive_q, drive_d;
  logic [8:0]        idx_q, idx_d;
  logic [DW-1:0]     wait_q, wait_d;
  logic [DW-1:0]     delay_q, delay_d;
  logic [TW-1:0]     tog_q, tog_d;
  kind_e             kind_q, kind_d;

  logic [47:0]       ticks_ext;
  logic [47:0]       count_ext;
  logic [DW-1:0]     delay_raw;
  logic [DW-1:0]     delay_eff;
  logic [CW-1:0]     count_in;
  logic [TW-1:0]     tog_start;
  logic [ColorW-1:0] on_color;
  logic [ColorW-1:0] on_word;
  logic [DW-1:0]     wait_dec;
  logic [8:0]        idx_inc;
  logic [ColorW-1:0] fade_color;
  logic [ColorW-1:0] wheel_next;
  logic [ColorW-1:0] wheel_first;

  assign ticks_ext = {32'd0, item_i.step_ticks};
  assign count_ext = {32'd0, item_i.blink_count};
  assign delay_raw = ticks_ext[DW-1:0];
  assign delay_eff = (delay_raw == '0) ? DW'(1) : delay_raw;
  assign count_in  = count_ext[CW-1:0];
  assign tog_start = {count_in, 1'b0};

  assign on_color  = (stored_q == '0) ? WhiteColor : stored_q;
  assign on_word   = (item_i.color_word == '0) ? WhiteColor : item_i.color_word;
  assign wait_dec  = (wait_q != '0) ? (wait_q - DW'(1)) : wait_q;
  assign idx_inc   = idx_q + 9'd1;

  assign fade_color = {fade_chan(start_q[23:16], stored_q[23:16], idx_inc[7:0]),
                       fade_chan(start_q[15:8],  stored_q[15:8],  idx_inc[7:0]),
                       fade_chan(start_q[7:0],   stored_q[7:0],   idx_inc[7:0])};
  assign wheel_next  = wheel(idx_inc[7:0]);
  assign wheel_first = wheel(8'd0);

  always_comb begin
    stored_d = stored_q;
    packed_d = packed_q;
    start_d  = start_q;
    drive_d  = drive_q;
    idx_d    = idx_q;
    wait_d   = wait_q;
    delay_d  = delay_q;
    tog_d    = tog_q;
    kind_d   = kind_q;

    if (fire_i) begin
      if (item_i.mode == MODE_TICK) begin
        if (kind_q != KIND_IDLE) begin
          wait_d = wait_dec;
          if (wait_dec == '0) begin
            case (kind_q)
              KIND_FADE: begin
                if (idx_q >= {1'b0, LastStep}) begin
                  drive_d = stored_q;
                  kind_d  = KIND_IDLE;
                end else begin
                  idx_d   = idx_inc;
                  drive_d = fade_color;
                  wait_d  = delay_q;
                end
              end
              KIND_BLINK: begin
                if (tog_q == '0) begin
                  kind_d = KIND_IDLE;
                end else begin
                  drive_d = (drive_q != '0) ? '0 : on_color;
                  tog_d   = tog_q - TW'(1);
                  wait_d  = delay_q;
                end
              end
              KIND_RAINBOW: begin
                if (idx_q >= {1'b0, LastStep}) begin
                  kind_d = KIND_IDLE;
                end else begin
                  idx_d    = idx_inc;
                  stored_d = wheel_next;
                  packed_d = wheel_next;
                  drive_d  = wheel_next;
                  wait_d   = delay_q;
                end
              end
              default: begin
                kind_d = KIND_IDLE;
              end
            endcase
          end
        end
      end else if (kind_q == KIND_IDLE) begin
        case (item_i.mode)
          MODE_SET: begin
            stored_d = item_i.color_word;
            packed_d = item_i.color_word;
            drive_d  = item_i.color_word;
          end
          MODE_STORE: begin
            stored_d = item_i.color_word;
            packed_d = item_i.color_word;
          end
          MODE_CLEAR: begin
            stored_d = '0;
            packed_d = '0;
            drive_d  = '0;
          end
          MODE_ON: begin
            drive_d = on_color;
          end
          MODE_OFF: begin
            drive_d = '0;
          end
          MODE_FADE: begin
            // The first fade step sits exactly on the start color.
            start_d  = stored_q;
            stored_d = item_i.color_word;
            packed_d = item_i.color_word;
            delay_d  = delay_eff;
            idx_d    = '0;
            kind_d   = KIND_FADE;
            drive_d  = stored_q;
            wait_d   = delay_eff;
          end
          MODE_BLINK: begin
            stored_d = item_i.color_word;
            packed_d = item_i.color_word;
            tog_d    = tog_start;
            if (tog_start != '0) begin
              delay_d = delay_eff;
              kind_d  = KIND_BLINK;
              drive_d = (drive_q != '0) ? '0 : on_word;
              tog_d   = tog_start - TW'(1);
              wait_d  = delay_eff;
            end
          end
          MODE_RAINBOW: begin
            delay_d  = delay_eff;
            idx_d    = '0;
            kind_d   = KIND_RAINBOW;
            stored_d = wheel_first;
            packed_d = wheel_first;
            drive_d  = wheel_first;
            wait_d   = delay_eff;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stored_q <= WhiteColor;
      packed_q <= '0;
      start_q  <= '0;
      drive_q  <= '0;
      idx_q    <= '0;
      wait_q   <= '0;
      delay_q  <= '0;
      tog_q    <= '0;
      kind_q   <= KIND_IDLE;
    end else begin
      stored_q <= stored_d;
      packed_q <= packed_d;
      start_q  <= start_d;
      drive_q  <= drive_d;
      idx_q    <= idx_d;
      wait_q   <= wait_d;
      delay_q  <= delay_d;
      tog_q    <= tog_d;
      kind_q   <= kind_d;
    end
  end

  assign result_o.drive_red    = drive_d[23:16];
  assign result_o.drive_green  = drive_d[15:8];
  assign result_o.drive_blue   = drive_d[7:0];
  assign result_o.busy_res     = (kind_d != KIND_IDLE);
  assign result_o.lit          = (drive_d != '0);
  assign result_o.stored_color = packed_d;

endmodule

// ===== sv/rles_out_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rles_out_reg
// Result register: holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module rles_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  rles_pkg::result_t result_i,
  output logic             free_o,
  output logic             valid_o,
  input  logic             ready_i,
  output rles_pkg::result_t result_o
);
  import rles_pkg::*;

  logic    valid_q;
  result_t result_q;

  assign free_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

// ===== sv/rgb_led_effect_sequencer_top.sv =====
`timescale 1ns / 1ps
// A transferred item waits in the input register until its result can be loaded into the
// result register; a result that waits there holds the next item in the input register.
// Throughput: one item per cycle while results are taken; the state update is one pass
// of logic between the input and result registers, so items may follow back to back.
// Reset: asynchronous, active low; LED dark, no effect running, stored channels
// white, stored color word zero, no item or result held.
// ----------------------------------------------------------------------------
// rgb_led_effect_sequencer_top
// RGB LED driver with color commands and timed fade, blink and rainbow effects.
// ----------------------------------------------------------------------------
module rgb_led_effect_sequencer_top #(
  parameter int unsigned DELAY_BITS = 16,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // color_word [23:0], step_ticks [39:24], blink_count [55:40]
  input  logic [55:0] s_axis_tdata,
  // mode [3:0]
  input  logic [3:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // drive_red [7:0], drive_green [15:8], drive_blue [23:16], busy_res [24],
  // lit [25], stored_color [49:26]
  output logic [55:0] m_axis_tdata
);
  import rles_pkg::*;

  item_t   item_in;
  item_t   item_held;
  logic    held_valid;
  logic    out_free;
  logic    fire;
  result_t result_d;
  result_t result_q;

  assign item_in.mode        = s_axis_tuser;
  assign item_in.color_word  = s_axis_tdata[23:0];
  assign item_in.step_ticks  = s_axis_tdata[39:24];
  assign item_in.blink_count = s_axis_tdata[55:40];

  assign fire = held_valid && out_free;

  rles_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .item_i  (item_in),
    .valid_o (held_valid),
    .item_o  (item_held),
    .take_i  (fire)
  );

  rles_core #(
    .DELAY_BITS (DELAY_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (item_held),
    .result_o (result_d)
  );

  rles_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (fire),
    .result_i (result_d),
    .free_o   (out_free),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .result_o (result_q)
  );

  assign m_axis_tdata = {6'd0, result_q.stored_color, result_q.lit, result_q.busy_res,
                         result_q.drive_blue, result_q.drive_green, result_q.drive_red};

endmodule
